// ----- design/lspfe_pkg.sv -----
package lspfe_pkg;

    localparam int BITS_PER_LED = 24;
    localparam int LEAD_ZEROS   = 2;
    localparam int PCT_FULL     = 100;

    localparam logic [6:0] BRIGHT_RST    = 7'd100;
    localparam logic [7:0] DUTY_ONE_RST  = 8'd39;
    localparam logic [7:0] DUTY_ZERO_RST = 8'd21;

    // x / 100 == (x * 5243) >> 19 for every x below 25600
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_WRITE      = 3'd1,
        CMD_FILL       = 3'd2,
        CMD_CLEAR_SEND = 3'd3,
        CMD_SEND       = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_DUTY_ONE   = 2'd1,
        CFG_DUTY_ZERO  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FILL,
        ST_COPY
    } t_state;

    typedef struct packed {
        logic start;
        logic tick;
        logic lat_we;
    } t_tx_ctl;

endpackage

// ----- design/lspfe_ram.sv -----
module lspfe_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/lspfe_scale.sv -----
module lspfe_scale
    import lspfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [6:0]  i_brightness,
    output logic        o_done,
    output logic [23:0] o_colour
);

    localparam int PROD_W  = 15;
    localparam int RECIP_W = PROD_W + 13;

    logic               r_busy;
    logic [1:0]         r_cnt;
    logic               r_done;
    logic [23:0]        r_in;
    logic [6:0]         r_br;
    logic [PROD_W-1:0]  r_prod;
    logic [23:0]        r_out;
    logic [RECIP_W-1:0] w_recip;
    logic [6:0]         w_br_sat;

    assign w_br_sat = (i_brightness > BRIGHT_RST) ? BRIGHT_RST : i_brightness;
    assign w_recip  = RECIP_W'(r_prod) * RECIP_W'(RECIP_100);

    // one colour byte per cycle: multiply by brightness, then divide by 100
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 2'd3);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_in <= {i_green, i_red, i_blue};
            r_br <= w_br_sat;
        end else if (r_busy) begin
            r_prod <= PROD_W'(r_in[23:16] * r_br);
            r_in   <= {r_in[15:0], 8'd0};
            if (r_cnt != 2'd0) begin
                r_out <= {r_out[15:0], w_recip[RECIP_SHIFT +: 8]};
            end
        end
    end

    assign o_done   = r_done;
    assign o_colour = r_out;

endmodule

// ----- design/lspfe_tx.sv -----
module lspfe_tx
    import lspfe_pkg::*;
#(
    parameter int LEDS_PER_SET = 8,
    parameter int LW = (LEDS_PER_SET > 1) ? $clog2(LEDS_PER_SET) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tx_ctl       i_ctl,
    input  logic [LW-1:0] i_lat_addr,
    input  logic [23:0]   i_lat_data,
    input  logic [7:0]    i_duty_one,
    input  logic [7:0]    i_duty_zero,
    output logic          o_sending,
    output logic          o_valid,
    output logic [7:0]    o_duty_word,
    output logic          o_frame_last
);

    localparam int FRAME_WORDS = LEAD_ZEROS + BITS_PER_LED * LEDS_PER_SET + 1;
    localparam int PW          = $clog2(FRAME_WORDS);

    localparam logic [PW-1:0] POS_LAST = PW'(FRAME_WORDS - 1);
    localparam logic [PW-1:0] POS_DATA = PW'(LEAD_ZEROS);
    localparam logic [PW-1:0] POS_PRE  = PW'(LEAD_ZEROS - 1);
    localparam logic [4:0]    BIT_LAST = 5'(BITS_PER_LED - 1);

    logic          r_sending;
    logic [PW-1:0] r_pos;
    logic [4:0]    r_bit;
    logic [LW-1:0] r_led;
    logic [23:0]   r_bits;
    logic          r_valid;
    logic [7:0]    r_word;
    logic          r_last;
    logic [23:0]   w_lat_rdata;
    logic          w_emit;
    logic          w_data;
    logic          w_is_last;
    logic          w_load;

    // frame copy of the selected set, read at the next led to be shifted out
    lspfe_ram #(
        .WIDTH (24),
        .DEPTH (LEDS_PER_SET),
        .ADDR_W(LW)
    ) u_latch (
        .i_clk  (i_clk),
        .i_we   (i_ctl.lat_we),
        .i_waddr(i_lat_addr),
        .i_wdata(i_lat_data),
        .i_raddr(r_led),
        .o_rdata(w_lat_rdata)
    );

    assign w_emit    = i_ctl.tick && r_sending;
    assign w_is_last = (r_pos == POS_LAST);
    assign w_data    = (r_pos >= POS_DATA) && !w_is_last;
    // preload the first led on the last lead zero, the next one after bit 23
    assign w_load    = (r_pos == POS_PRE) || (w_data && (r_bit == BIT_LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending <= 1'b0;
            r_pos     <= '0;
            r_bit     <= '0;
            r_led     <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= w_emit;
            if (i_ctl.start) begin
                r_sending <= 1'b1;
                r_pos     <= '0;
                r_bit     <= '0;
                r_led     <= '0;
            end else if (w_emit) begin
                if (w_is_last) begin
                    r_sending <= 1'b0;
                    r_pos     <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
                if (w_data) begin
                    r_bit <= (r_bit == BIT_LAST) ? 5'd0 : r_bit + 5'd1;
                end
                if (w_load) begin
                    r_led <= r_led + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_last <= w_is_last;
            if (w_data) begin
                r_word <= r_bits[23] ? i_duty_one : i_duty_zero;
            end else begin
                r_word <= 8'd0;
            end
            if (w_load) begin
                r_bits <= w_lat_rdata;
            end else if (w_data) begin
                r_bits <= {r_bits[22:0], 1'b0};
            end
        end
    end

    assign o_sending    = r_sending;
    assign o_valid      = r_valid;
    assign o_duty_word  = r_word;
    assign o_frame_last = r_last;

endmodule

// ----- design/led_strip_pulse_frame_encoder.sv -----
// LED strip pulse frame encoder.
// Commands come in on start/busy: a command is taken at a clock edge with start
// high and busy low. Tick emits the next timer compare word of a running frame on
// o_duty_word / o_frame_last, strobed by o_valid for one cycle, in the cycle right
// after the tick is taken; a tick leaves the state idle, so the next command may follow at once.
// Write one LED: the colour passes through the byte-serial colour scaler (one byte per
// cycle, multiply then reciprocal divide); if the set was cleared since it was last
// filled, the whole row is then rewritten.
// Fill set: the scaler runs first, then one pixel memory write per cycle.
// Send and clear-and-send copy the set through the pixel memory read port into the
// frame latch; while a frame runs, clear-and-send only clears and stays idle.
// Words leave the frame shift register one bit per tick: 2 zero words, 24 words per
// LED, then a flagged trailing zero. The config channel (i_cfg_valid / o_cfg_ready)
// is always ready; the user must see that it is written only while the block is idle,
// which the block does not enforce. Reset is synchronous: the config registers go to
// their defaults, every pixel set reads as zero and no frame is running. There is no
// back pressure on the result side; a word is gone after its cycle.
module led_strip_pulse_frame_encoder
    import lspfe_pkg::*;
#(
    parameter int NUM_SETS     = 16,
    parameter int LEDS_PER_SET = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_cmd,
    input  logic [3:0] i_set_index,
    input  logic [2:0] i_led_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    output logic       o_valid,
    output logic [7:0] o_duty_word,
    output logic       o_frame_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int PIX_DEPTH = NUM_SETS * LEDS_PER_SET;
    localparam int PAW       = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int SW        = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int LW        = (LEDS_PER_SET > 1) ? $clog2(LEDS_PER_SET) : 1;
    localparam int CW        = $clog2(LEDS_PER_SET + 1);
    localparam int SEND_SET  = 1 % NUM_SETS;

    t_state              r_state, n_state;
    logic [SW-1:0]       r_set, n_set;
    logic [LW-1:0]       r_led, n_led;
    logic                r_fill, n_fill;
    logic [CW-1:0]       r_idx, n_idx;
    logic [NUM_SETS-1:0] r_set_valid, n_set_valid;
    logic [6:0]          r_brightness;
    logic [7:0]          r_duty_one;
    logic [7:0]          r_duty_zero;

    t_cmd          w_cmd;
    logic          w_accept;
    logic          w_set_ok;
    logic          w_led_ok;
    logic          w_sc_start;
    logic          w_sc_done;
    logic [23:0]   w_colour;
    logic [PAW-1:0] w_base;
    logic          w_pix_we;
    logic [PAW-1:0] w_pix_waddr;
    logic [23:0]   w_pix_wdata;
    logic [PAW-1:0] w_pix_raddr;
    logic [23:0]   w_pix_rdata;
    logic [LW-1:0] w_lat_addr;
    logic [23:0]   w_lat_data;
    t_tx_ctl       w_tx_ctl;
    logic          w_sending;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cmd       = t_cmd'(i_cmd);
    assign w_set_ok    = int'(i_set_index) < NUM_SETS;
    assign w_led_ok    = int'(i_led_index) < LEDS_PER_SET;
    assign w_base      = PAW'(int'(r_set) * LEDS_PER_SET);
    assign w_pix_raddr = w_base + PAW'(r_idx);
    assign w_lat_addr  = LW'(r_idx - 1'b1);
    // a set cleared since its last fill reads as black
    assign w_lat_data  = r_set_valid[r_set] ? w_pix_rdata : 24'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHT_RST;
            r_duty_one   <= DUTY_ONE_RST;
            r_duty_zero  <= DUTY_ZERO_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BRIGHTNESS: r_brightness <= i_cfg_data[6:0];
                CFG_DUTY_ONE:   r_duty_one   <= i_cfg_data;
                CFG_DUTY_ZERO:  r_duty_zero  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_set_valid <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_set_valid <= n_set_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_set  <= n_set;
        r_led  <= n_led;
        r_fill <= n_fill;
    end

    always_comb begin
        n_state     = r_state;
        n_set       = r_set;
        n_led       = r_led;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_set_valid = r_set_valid;
        w_sc_start  = 1'b0;
        w_pix_we    = 1'b0;
        w_pix_waddr = w_base + PAW'(r_idx);
        w_pix_wdata = (r_fill || (LW'(r_idx) == r_led)) ? w_colour : 24'd0;
        w_tx_ctl    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_TICK: w_tx_ctl.tick = 1'b1;
                        CMD_WRITE: begin
                            if (w_set_ok && w_led_ok) begin
                                w_sc_start = 1'b1;
                                n_set      = SW'(i_set_index);
                                n_led      = LW'(i_led_index);
                                n_fill     = 1'b0;
                                n_state    = ST_SCALE;
                            end
                        end
                        CMD_FILL: begin
                            if (w_set_ok) begin
                                w_sc_start = 1'b1;
                                n_set      = SW'(i_set_index);
                                n_fill     = 1'b1;
                                n_state    = ST_SCALE;
                            end
                        end
                        CMD_CLEAR_SEND: begin
                            n_set_valid = '0;
                            if (!w_sending) begin
                                n_set   = SW'(SEND_SET);
                                n_idx   = '0;
                                n_state = ST_COPY;
                            end
                        end
                        CMD_SEND: begin
                            if (w_set_ok && !w_sending) begin
                                n_set   = SW'(i_set_index);
                                n_idx   = '0;
                                n_state = ST_COPY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCALE: begin
                if (w_sc_done) begin
                    n_idx = '0;
                    if (!r_fill && r_set_valid[r_set]) begin
                        w_pix_we    = 1'b1;
                        w_pix_waddr = w_base + PAW'(r_led);
                        w_pix_wdata = w_colour;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                w_pix_we = 1'b1;
                n_idx    = r_idx + 1'b1;
                if (r_idx == CW'(LEDS_PER_SET - 1)) begin
                    n_set_valid[r_set] = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            ST_COPY: begin
                // the pixel memory read is registered, so the latch write trails the read
                w_tx_ctl.lat_we = (r_idx != '0);
                n_idx           = r_idx + 1'b1;
                if (r_idx == CW'(LEDS_PER_SET)) begin
                    w_tx_ctl.start = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    lspfe_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_sc_start),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_brightness(r_brightness),
        .o_done      (w_sc_done),
        .o_colour    (w_colour)
    );

    lspfe_ram #(
        .WIDTH (24),
        .DEPTH (PIX_DEPTH),
        .ADDR_W(PAW)
    ) u_pixels (
        .i_clk  (i_clk),
        .i_we   (w_pix_we),
        .i_waddr(w_pix_waddr),
        .i_wdata(w_pix_wdata),
        .i_raddr(w_pix_raddr),
        .o_rdata(w_pix_rdata)
    );

    lspfe_tx #(
        .LEDS_PER_SET(LEDS_PER_SET),
        .LW          (LW)
    ) u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_tx_ctl),
        .i_lat_addr  (w_lat_addr),
        .i_lat_data  (w_lat_data),
        .i_duty_one  (r_duty_one),
        .i_duty_zero (r_duty_zero),
        .o_sending   (w_sending),
        .o_valid     (o_valid),
        .o_duty_word (o_duty_word),
        .o_frame_last(o_frame_last)
    );

    a_word_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_cmd == CMD_TICK)))
        else $error("result word without a tick request");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |-> !w_sending)
        else $error("frame still running after its last word");

    a_copy_when_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> !w_sending)
        else $error("frame latch overwritten during a running frame");

    a_scale_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sc_done |-> (r_state == ST_SCALE))
        else $error("colour scaler finished outside a write request");

endmodule

// ----- tb/lspfe_checker.sv -----
`timescale 1ns / 100ps

module lspfe_checker
    import lspfe_pkg::*;
#(
    parameter int NUM_SETS     = 16,
    parameter int LEDS_PER_SET = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_busy,
    input  logic [2:0] i_cmd,
    input  logic [3:0] i_set_index,
    input  logic [2:0] i_led_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    input  logic       i_valid,
    input  logic [7:0] i_duty_word,
    input  logic       i_frame_last,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int FRAME_WORDS = LEAD_ZEROS + BITS_PER_LED * LEDS_PER_SET + 1;
    localparam int PCT         = 100;

    typedef struct packed {
        logic [7:0] duty;
        logic       last;
    } t_pulse_word;

    t_pulse_word words_due[$];

    logic [23:0] pixel_mem  [NUM_SETS][LEDS_PER_SET];
    logic [23:0] frame_copy [LEDS_PER_SET];
    logic [6:0]  bright_pct;
    logic [7:0]  one_code;
    logic [7:0]  zero_code;
    logic        frame_on;
    int          slot;
    int          fails;

    function automatic logic [7:0] scale_channel(input logic [7:0] c);
        int lvl;
        // brightness above full scale saturates
        lvl = (int'(bright_pct) > PCT) ? PCT : int'(bright_pct);
        return 8'((int'(c) * lvl) / PCT);
    endfunction

    function automatic logic [23:0] pack_grb(input logic [7:0] r, input logic [7:0] b,
                                             input logic [7:0] g);
        return {scale_channel(g), scale_channel(r), scale_channel(b)};
    endfunction

    task automatic latch_frame(input int set);
        if (frame_on || set >= NUM_SETS)
            return;
        for (int i = 0; i < LEDS_PER_SET; i++)
            frame_copy[i] = pixel_mem[set][i];
        frame_on = 1'b1;
        slot     = 0;
    endtask

    task automatic take_request();
        t_pulse_word w;
        int          k;
        logic [23:0] colour;
        case (i_cmd)
            CMD_TICK: begin
                if (frame_on) begin
                    w.duty = 8'd0;
                    if (slot >= LEAD_ZEROS && slot < FRAME_WORDS - 1) begin
                        k = slot - LEAD_ZEROS;
                        w.duty = frame_copy[k / BITS_PER_LED][BITS_PER_LED - 1 - k % BITS_PER_LED]
                                 ? one_code : zero_code;
                    end
                    w.last = (slot >= FRAME_WORDS - 1);
                    if (w.last) begin
                        frame_on = 1'b0;
                        slot     = 0;
                    end else begin
                        slot++;
                    end
                    words_due.push_back(w);
                end
            end
            CMD_WRITE: begin
                if (int'(i_set_index) < NUM_SETS && int'(i_led_index) < LEDS_PER_SET)
                    pixel_mem[i_set_index][i_led_index] = pack_grb(i_red, i_blue, i_green);
            end
            CMD_FILL: begin
                if (int'(i_set_index) < NUM_SETS) begin
                    colour = pack_grb(i_red, i_blue, i_green);
                    for (int i = 0; i < LEDS_PER_SET; i++)
                        pixel_mem[i_set_index][i] = colour;
                end
            end
            CMD_CLEAR_SEND: begin
                for (int s = 0; s < NUM_SETS; s++)
                    for (int i = 0; i < LEDS_PER_SET; i++)
                        pixel_mem[s][i] = '0;
                latch_frame(1 % NUM_SETS);
            end
            CMD_SEND: begin
                latch_frame(int'(i_set_index));
            end
            default: ;
        endcase
    endtask

    initial begin
        fails = 0;
    end

    always @(posedge i_clk) begin : watch_proc
        t_pulse_word want;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++)
                for (int i = 0; i < LEDS_PER_SET; i++)
                    pixel_mem[s][i] = '0;
            for (int i = 0; i < LEDS_PER_SET; i++)
                frame_copy[i] = '0;
            bright_pct = BRIGHT_RST;
            one_code   = DUTY_ONE_RST;
            zero_code  = DUTY_ZERO_RST;
            frame_on   = 1'b0;
            slot       = 0;
            words_due.delete();
        end else begin
            if (i_valid) begin
                if (words_due.size() == 0) begin
                    $error("unexpected result: duty_word %0d frame_last %0d",
                           i_duty_word, i_frame_last);
                    fails++;
                end else begin
                    want = words_due.pop_front();
                    if (i_duty_word !== want.duty) begin
                        $error("duty_word: expected %0d, got %0d", want.duty, i_duty_word);
                        fails++;
                    end
                    if (i_frame_last !== want.last) begin
                        $error("frame_last: expected %0d, got %0d", want.last, i_frame_last);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BRIGHTNESS: bright_pct = i_cfg_data[6:0];
                    CFG_DUTY_ONE:   one_code   = i_cfg_data;
                    CFG_DUTY_ZERO:  zero_code  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                take_request();
        end
        o_pending    <= words_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- tb/tb_led_strip_pulse_frame_encoder.sv -----
`timescale 1ns / 100ps

module tb_led_strip_pulse_frame_encoder;
    import lspfe_pkg::*;

    localparam int NUM_SETS     = 16;
    localparam int LEDS_PER_SET = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 175;

    // codes with no command behind them
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [2:0] i_cmd;
    logic [3:0] i_set_index;
    logic [2:0] i_led_index;
    logic [7:0] i_red;
    logic [7:0] i_blue;
    logic [7:0] i_green;
    logic       o_valid;
    logic [7:0] o_duty_word;
    logic       o_frame_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    int fail_count;
    int pending;
    int idle_cycles;

    led_strip_pulse_frame_encoder #(
        .NUM_SETS     (NUM_SETS),
        .LEDS_PER_SET (LEDS_PER_SET)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_set_index  (i_set_index),
        .i_led_index  (i_led_index),
        .i_red        (i_red),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .o_valid      (o_valid),
        .o_duty_word  (o_duty_word),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    lspfe_checker #(
        .NUM_SETS     (NUM_SETS),
        .LEDS_PER_SET (LEDS_PER_SET)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_set_index  (i_set_index),
        .i_led_index  (i_led_index),
        .i_red        (i_red),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_valid      (o_valid),
        .i_duty_word  (o_duty_word),
        .i_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ends the run when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic issue_request(input logic [2:0] cmd, input logic [3:0] set,
                                 input logic [2:0] led, input logic [7:0] r,
                                 input logic [7:0] b, input logic [7:0] g);
        @(negedge i_clk);
        start       <= 1'b1;
        i_cmd       <= cmd;
        i_set_index <= set;
        i_led_index <= led;
        i_red       <= r;
        i_blue      <= b;
        i_green     <= g;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic issue_random();
        int          pick;
        logic [2:0]  cmd;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            cmd = CMD_TICK;
        else if (pick < 76)
            cmd = CMD_WRITE;
        else if (pick < 84)
            cmd = CMD_FILL;
        else if (pick < 91)
            cmd = CMD_SEND;
        else if (pick < 93)
            cmd = CMD_CLEAR_SEND;
        else
            cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
        issue_request(cmd, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
    endtask

    // registers only change once every word due has come out
    task automatic set_levels(input logic [7:0] bright, input logic [7:0] one_code,
                              input logic [7:0] zero_code);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_BRIGHTNESS;
        i_cfg_data  <= bright;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= CFG_DUTY_ONE;
        i_cfg_data  <= one_code;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= CFG_DUTY_ZERO;
        i_cfg_data  <= zero_code;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] bright_plan [PHASES];
        logic [7:0] one_plan    [PHASES];
        logic [7:0] zero_plan   [PHASES];
        int         gap_pct;

        bright_plan = '{8'd0, 8'hFF, 8'd100, 8'd1, 8'd99, 8'd0, 8'd50, 8'd100};
        one_plan    = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd39};
        zero_plan   = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd21};

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cmd       = CMD_TICK;
        i_set_index = '0;
        i_led_index = '0;
        i_red       = '0;
        i_blue      = '0;
        i_green     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BRIGHTNESS;
        i_cfg_data  = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // tick with no frame running gives nothing
        issue_request(CMD_TICK, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);
        issue_request(CMD_WRITE, 4'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF);
        issue_request(CMD_WRITE, 4'd0, 3'd7, 8'h00, 8'h00, 8'h00);
        issue_request(CMD_WRITE, 4'd0, 3'd2, 8'hAA, 8'h55, 8'h0F);
        issue_request(CMD_WRITE, 4'd15, 3'd7, 8'h80, 8'h01, 8'hFE);
        issue_request(CMD_FILL, 4'd15, 3'd3, 8'h01, 8'h80, 8'hFE);
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
            issue_request(3'(c), 4'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF);
        issue_request(CMD_SEND, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);
        issue_request(CMD_TICK, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);
        // a second send mid-frame is dropped and the frame runs on
        issue_request(CMD_SEND, 4'd15, 3'd0, 8'd0, 8'd0, 8'd0);
        // writes during a frame leave the latched copy alone
        issue_request(CMD_WRITE, 4'd0, 3'd1, 8'hFF, 8'h00, 8'hFF);
        for (int i = 0; i < 3; i++)
            issue_request(CMD_TICK, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);
        // clear still wipes every set while the send part is dropped
        issue_request(CMD_CLEAR_SEND, 4'd7, 3'd0, 8'd0, 8'd0, 8'd0);
        for (int i = 0; i < 4; i++)
            issue_request(CMD_TICK, 4'd0, 3'd0, 8'd0, 8'd0, 8'd0);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 4 || p == 5) begin
                one_plan[p]  = 8'($urandom_range(0, 255));
                zero_plan[p] = 8'($urandom_range(0, 255));
            end
            if (p == 5)
                bright_plan[p] = 8'($urandom_range(0, 255));
            set_levels(bright_plan[p], one_plan[p], zero_plan[p]);
            gap_pct = (p % 4 == 1) ? 54 : (p % 4 == 3) ? 8 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // each cycle the sender stays idle with the phase's odds
                while (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct)
                    hold_off(1);
                issue_random();
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
design/lspfe_pkg.sv
design/lspfe_ram.sv
design/lspfe_scale.sv
design/lspfe_tx.sv
design/led_strip_pulse_frame_encoder.sv
tb/lspfe_checker.sv
tb/tb_led_strip_pulse_frame_encoder.sv
